>>> rtl/elementary_symmetric_polynomials_defines.svh
// assertion macros shared by the block
`ifndef ELEMENTARY_SYMMETRIC_POLYNOMIALS_DEFINES_SVH
`define ELEMENTARY_SYMMETRIC_POLYNOMIALS_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ESP_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ESP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/esp_pkg.sv
package esp_pkg;

    localparam int DEF_MAX_ORDER = 16;
    localparam int FP_W          = 32;
    localparam int DEG_W         = 5;
    localparam logic [FP_W-1:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

    // control shared by every cell of the chain
    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctl_t;

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // round a value sign * m * 2^(e - 127 - 47): e is the biased exponent the
    // value would have with its leading bit at 47; ties to even, subnormals kept
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [49:0] m);
        logic [49:0] mm;
        logic signed [11:0] ee;
        logic [5:0] p;
        logic [11:0] rs;
        logic [49:0] lost;
        logic [24:0] r;
        logic g;
        logic st;
        p = 6'd0;
        mm = m;
        ee = e;
        rs = 12'd0;
        lost = 50'd0;
        r = 25'd0;
        g = 1'b0;
        st = 1'b0;
        if (m == 50'd0)
            return {sgn, 31'd0};
        // find the leading one and move it to bit 49
        for (int i = 0; i < 50; i++)
        begin
            if (m[i])
                p = 6'(i);
        end
        mm = m << (6'd49 - p);
        ee = e + $signed({6'd0, p}) - 12'sd47;
        // below the normal range: shift into subnormal position with sticky
        if (ee < 12'sd1)
        begin
            rs = 12'(12'sd1 - ee);
            if (rs > 12'd50)
                rs = 12'd50;
            lost = mm & ((50'd1 << rs) - 50'd1);
            mm = (mm >> rs) | {49'd0, (lost != 50'd0)};
            ee = 12'sd0;
        end
        r = {1'b0, mm[49:26]};
        g = mm[25];
        st = mm[24:0] != 25'd0;
        r = r + 25'(g && (st || r[0]));
        if (r[24])
        begin
            r = r >> 1;
            ee = ee + 12'sd1;
        end
        if (ee == 12'sd0 && r[23])
            ee = 12'sd1;
        if (ee >= 12'sd255)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, ee[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        logic [23:0] ma;
        logic [23:0] mb;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic [47:0] p;
        sgn = a[31] ^ b[31];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        ea = (a[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(a[30:23]));
        eb = (b[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(b[30:23]));
        p = 48'(ma) * 48'(mb);
        if (fp_is_nan(a) || fp_is_nan(b))
            return FP_QNAN;
        if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a)))
            return FP_QNAN;
        if (fp_is_inf(a) || fp_is_inf(b))
            return {sgn, 8'hFF, 23'd0};
        // product leading bit at 46 or 47 for 1.x * 1.x; place at 47 scale
        return fp_round(sgn, ea + eb - 12'sd127 + 12'sd0, {1'b0, p, 1'b0});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic signed [11:0] eb;
        logic signed [11:0] el;
        logic [49:0] mb;
        logic [49:0] ml;
        logic [49:0] lost;
        logic [11:0] d;
        logic [49:0] s;
        if (fp_is_nan(a) || fp_is_nan(b))
            return FP_QNAN;
        if (fp_is_inf(a) && fp_is_inf(b))
            return (a[31] == b[31]) ? a : FP_QNAN;
        if (fp_is_inf(a))
            return a;
        if (fp_is_inf(b))
            return b;
        if (fp_is_zero(a) && fp_is_zero(b))
            return {a[31] & b[31], 31'd0};
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            lit = b;
        end
        else
        begin
            big = b;
            lit = a;
        end
        eb = (big[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(big[30:23]));
        el = (lit[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(lit[30:23]));
        mb = {2'b0, (big[30:23] != 8'd0), big[22:0], 24'd0};
        ml = {2'b0, (lit[30:23] != 8'd0), lit[22:0], 24'd0};
        d = 12'(eb - el);
        if (d > 12'd49)
            d = 12'd49;
        lost = ml & ((50'd1 << d) - 50'd1);
        ml = (ml >> d) | {49'd0, (lost != 50'd0)};
        s = (big[31] == lit[31]) ? mb + ml : mb - ml;
        if (s == 50'd0)
            return 32'd0;
        // leading bit of mb sits at 47: value = m * 2^(eb-127-47)
        return fp_round(big[31], eb, s);
    endfunction

endpackage

>>> rtl/esp_cell.sv
module esp_cell
    import esp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctl_t       ctl,
    input  logic [FP_W-1:0] x,
    input  logic [FP_W-1:0] lower,
    input  logic [FP_W-1:0] shift_in,
    output logic [FP_W-1:0] value
);

    logic [FP_W-1:0] value_reg;
    logic [FP_W-1:0] value_next;
    logic [FP_W-1:0] prod_reg;
    logic [FP_W-1:0] prod_next;

    // product stage: x times the lower neighbor (old value)
    assign prod_next = fp_mul(x, lower);

    // add stage on load, otherwise take shift_in: hold or rotate toward the output
    always_comb
    begin
        value_next = shift_in;
        if (ctl.load)
            value_next = fp_add(ctl.clear ? '0 : value_reg, prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/elementary_symmetric_polynomials.sv
// elementary symmetric polynomials of a stream of binary32 eigenvalues
// input channel: eigenvalue and start_set under valid/ready; start_set
//   clears the row e_1..e_MAX_ORDER before the update
// config: write order by order_we/order_wdata only while idle (not enforced)
// each request runs the update (multiply, then add in every cell of the
//   chain at once), then the row rotates through the chain until it returns
//   home, one degree per cycle out of cell 0 while the output can take it
// output channel: poly_value, degree, row_last under valid/ready; results
//   1..order (order clamped to 1..MAX_ORDER) come in rising degree, row_last
//   on the last one
// a request goes through accept, multiply, add and rotation; the first
//   result is registered at the first rotation step; the next request is
//   taken once rotation ends
// output is a register; if the receiver stalls, the rotation holds
// reset: row cleared to +0, order 1, both channels empty
module elementary_symmetric_polynomials
    import esp_pkg::*;
#(
    parameter int MAX_ORDER = DEF_MAX_ORDER
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     eigenvalue,
    input  logic            start_set,
    input  logic            order_we,
    input  logic [4:0]      order_wdata,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     poly_value,
    output logic [4:0]      degree,
    output logic            row_last
);

`include "elementary_symmetric_polynomials_defines.svh"

    localparam int CW = $clog2(MAX_ORDER + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_ROT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [4:0]      order_reg;
    logic [31:0]     x_reg;
    logic            clr_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   kk;
    logic            out_valid_reg;
    logic [31:0]     out_val_reg;
    logic [4:0]      out_deg_reg;
    logic            out_last_reg;
    logic            step;
    cell_ctl_t       ctl;
    logic [31:0]     val [MAX_ORDER];
    logic [31:0]     lower [MAX_ORDER];

    // clamp order into 1..MAX_ORDER
    always_comb
    begin
        if (order_reg == 5'd0)
            kk = CW'(1);
        else if (32'(order_reg) > MAX_ORDER)
            kk = CW'(MAX_ORDER);
        else
            kk = CW'(order_reg);
    end

    assign in_ready = (state_reg == ST_IDLE);
    // a rotation step happens when the output register can take a value
    assign step = (state_reg == ST_ROT) && (!out_valid_reg || out_ready);
    assign ctl.load  = (state_reg == ST_ADD);
    assign ctl.clear = clr_reg;

    // chain of cells, cell 0 holds e_1 and reads the constant e_0 = 1;
    // on a new set the lower neighbors read as +0
    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_cell
        logic [31:0] sin;
        logic [31:0] lo;
        assign lo  = (i == 0) ? FP_ONE : (clr_reg ? '0 : val[(i == 0) ? 0 : i - 1]);
        assign lower[i] = lo;
        assign sin = !step ? val[i] : val[(i + 1) % MAX_ORDER];
        esp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .x        (x_reg),
            .lower    (lower[i]),
            .shift_in (sin),
            .value    (val[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:
            begin
                state_next = ST_ROT;
                cnt_next = '0;
            end
            ST_ROT:
            begin
                if (step)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MAX_ORDER - 1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            order_reg <= 5'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (order_we)
                order_reg <= order_wdata;
            if (step)
                out_valid_reg <= (cnt_reg < kk);
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture and output register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= eigenvalue;
            clr_reg <= start_set;
        end
        if (step)
        begin
            out_val_reg <= val[0];
            out_deg_reg <= 5'(cnt_reg + CW'(1));
            out_last_reg <= (cnt_reg + CW'(1) == kk);
        end
    end

    assign out_valid  = out_valid_reg;
    assign poly_value = out_val_reg;
    assign degree     = out_deg_reg;
    assign row_last   = out_last_reg;

    `ESP_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `ESP_ASSERT_NEXT(a_mul_add, clk, rst_n, state_reg == ST_MUL, state_reg == ST_ADD, "mul not followed by add")
    `ESP_ASSERT_IMPL(a_last_deg, clk, rst_n, out_valid && row_last, CW'(degree) == kk, "row_last off order")
    `ESP_ASSERT_IMPL(a_deg_range, clk, rst_n, out_valid, degree != 5'd0, "degree zero")

endmodule
